### src/iorm_pkg.sv
// Shared constants, codes and types of the IOVA range map table.
package iorm_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int ADDR_BITS     = 48;
    localparam int SPAN_BITS     = ADDR_BITS + 1;
    localparam int END_BITS      = ADDR_BITS + 2;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int USED_W        = 7;

    localparam logic [MODE_W-1:0] MODE_MAP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNMAP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BULK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ROLLBACK = 3'd5;

    typedef struct packed {
        logic [ADDR_BITS-1:0] io_base;
        logic [ADDR_BITS-1:0] phys_base;
        logic [SPAN_BITS-1:0] span;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic overlap;
        logic exact;
    } t_cmp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

endpackage

### src/iova_range_map_table_core.sv
// IOVA range map table: request decode, table scan sequencer and result register.
// Scan: map, unmap and (outside a failed batch) bulk requests with nonzero span sweep every
// RAM entry, one per cycle; S_FIN then registers the result once the result register is free.
// The single RAM read port sets the sweep pace; items needing no sweep go straight to S_FIN.
// o_ready is low outside S_IDLE. A waiting result does not block the next input beat.
// Reset: entry valid and batch bits, counters and handshake clear at once; no clearing pass.
module iova_range_map_table_core import iorm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [MODE_W-1:0]      i_mode,
    input  logic [ADDR_BITS-1:0]   i_io_base,
    input  logic [ADDR_BITS-1:0]   i_phys_base,
    input  logic [SPAN_BITS-1:0]   i_span,
    input  logic                   i_batch_last,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [STATUS_W-1:0]    o_status,
    output logic [USED_W-1:0]      o_used_count
);

    localparam int IDX_CW = IDX_W + 1;

    t_state                 r_state, n_state;
    logic [TABLE_ENTRIES-1:0] r_valid_vec, n_valid_vec;
    logic [TABLE_ENTRIES-1:0] r_batch_vec, n_batch_vec;
    logic                   r_batch_failed, n_batch_failed;
    logic [CNT_W-1:0]       r_used, n_used;
    logic [CNT_W-1:0]       r_batch_cnt, n_batch_cnt;
    logic                   r_out_vld, n_out_vld;
    logic                   r_chk_vld, n_chk_vld;

    logic [MODE_W-1:0]      r_mode, n_mode;
    logic [ADDR_BITS-1:0]   r_base, n_base;
    logic [ADDR_BITS-1:0]   r_phys, n_phys;
    logic [SPAN_BITS-1:0]   r_span, n_span;
    logic [END_BITS-1:0]    r_end, n_end;
    logic                   r_last, n_last;
    logic                   r_zero, n_zero;
    logic [IDX_CW-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]       r_chk_idx, n_chk_idx;
    logic                   r_hit, n_hit;
    logic [IDX_W-1:0]       r_hit_idx, n_hit_idx;
    logic                   r_free_found, n_free_found;
    logic [IDX_W-1:0]       r_free_idx, n_free_idx;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [USED_W-1:0]      r_used_out, n_used_out;

    logic                   rd_en;
    logic                   ram_we;
    t_entry                 ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;
    t_entry                 rd_entry;
    t_cmp                   cmp;
    logic                   out_free;
    logic                   need_scan;
    logic [STATUS_W-1:0]    map_st;

    assign rd_entry  = t_entry'(ram_rdata);
    assign ram_wdata = '{io_base: r_base, phys_base: r_phys, span: r_span};

    iorm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    iorm_cmp u_cmp (
        .i_entry (rd_entry),
        .i_base  (r_base),
        .i_span  (r_span),
        .i_end   (r_end),
        .o_cmp   (cmp)
    );

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_vld;
    assign o_status     = r_status;
    assign o_used_count = r_used_out;
    assign out_free     = !r_out_vld || i_ready;
    assign rd_en        = (r_state == S_SCAN) && (r_idx < IDX_CW'(TABLE_ENTRIES));

    always_comb begin
        n_state        = r_state;
        n_valid_vec    = r_valid_vec;
        n_batch_vec    = r_batch_vec;
        n_batch_failed = r_batch_failed;
        n_used         = r_used;
        n_batch_cnt    = r_batch_cnt;
        n_out_vld      = r_out_vld;
        n_chk_vld      = r_chk_vld;
        n_mode         = r_mode;
        n_base         = r_base;
        n_phys         = r_phys;
        n_span         = r_span;
        n_end          = r_end;
        n_last         = r_last;
        n_zero         = r_zero;
        n_idx          = r_idx;
        n_chk_idx      = r_chk_idx;
        n_hit          = r_hit;
        n_hit_idx      = r_hit_idx;
        n_free_found   = r_free_found;
        n_free_idx     = r_free_idx;
        n_status       = r_status;
        n_used_out     = r_used_out;
        ram_we         = 1'b0;
        need_scan      = 1'b0;

        if (r_zero) begin
            map_st = ST_ZERO;
        end else if (r_hit) begin
            map_st = ST_OVERLAP;
        end else if (!r_free_found) begin
            map_st = ST_FULL;
        end else begin
            map_st = ST_OK;
        end

        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode       = i_mode;
                    n_base       = i_io_base;
                    n_phys       = i_phys_base;
                    n_span       = i_span;
                    n_end        = END_BITS'(i_io_base) + END_BITS'(i_span);
                    n_last       = i_batch_last;
                    n_zero       = (i_span == '0);
                    n_idx        = '0;
                    n_chk_vld    = 1'b0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    need_scan    = (i_mode == MODE_MAP) || (i_mode == MODE_UNMAP) ||
                                   ((i_mode == MODE_BULK) && !r_batch_failed);
                    n_state      = (need_scan && (i_span != '0)) ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_idx = r_idx + IDX_CW'(1);
                end
                n_chk_vld = rd_en;
                n_chk_idx = r_idx[IDX_W-1:0];
                if (r_chk_vld) begin
                    if (r_valid_vec[r_chk_idx]) begin
                        if (((r_mode == MODE_UNMAP) ? cmp.exact : cmp.overlap) && !r_hit) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_chk_idx;
                        end
                    end else if (!r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_chk_idx;
                    end
                    if (r_chk_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                // hold until the result register can take the beat
                if (out_free) begin
                    n_status = ST_OK;
                    case (r_mode)
                        MODE_MAP: begin
                            n_status = map_st;
                            if (map_st == ST_OK) begin
                                ram_we                  = 1'b1;
                                n_valid_vec[r_free_idx] = 1'b1;
                                n_batch_vec[r_free_idx] = 1'b0;
                                n_used                  = r_used + CNT_W'(1);
                            end
                        end
                        MODE_UNMAP: begin
                            if (r_zero) begin
                                n_status = ST_ZERO;
                            end else if (r_hit) begin
                                n_valid_vec[r_hit_idx] = 1'b0;
                                n_batch_vec[r_hit_idx] = 1'b0;
                                n_used                 = r_used - CNT_W'(1);
                                if (r_batch_vec[r_hit_idx]) begin
                                    n_batch_cnt = r_batch_cnt - CNT_W'(1);
                                end
                            end else begin
                                n_status = ST_NOTFOUND;
                            end
                        end
                        MODE_BULK: begin
                            if (r_batch_failed) begin
                                // skip until the last element of the failed batch
                                n_status = ST_ROLLBACK;
                                if (r_last) begin
                                    n_batch_failed = 1'b0;
                                end
                            end else if (map_st == ST_OK) begin
                                ram_we                  = 1'b1;
                                n_valid_vec[r_free_idx] = 1'b1;
                                n_used                  = r_used + CNT_W'(1);
                                if (r_last) begin
                                    n_batch_vec = '0;
                                    n_batch_cnt = '0;
                                end else begin
                                    n_batch_vec[r_free_idx] = 1'b1;
                                    n_batch_cnt             = r_batch_cnt + CNT_W'(1);
                                end
                            end else begin
                                // drop every entry of the open batch
                                n_valid_vec    = r_valid_vec & ~r_batch_vec;
                                n_batch_vec    = '0;
                                n_used         = r_used - r_batch_cnt;
                                n_batch_cnt    = '0;
                                n_status       = r_last ? ST_ROLLBACK : map_st;
                                n_batch_failed = !r_last;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                    n_used_out = USED_W'(n_used);
                    n_out_vld  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_valid_vec    <= '0;
            r_batch_vec    <= '0;
            r_batch_failed <= 1'b0;
            r_used         <= '0;
            r_batch_cnt    <= '0;
            r_out_vld      <= 1'b0;
            r_chk_vld      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_valid_vec    <= n_valid_vec;
            r_batch_vec    <= n_batch_vec;
            r_batch_failed <= n_batch_failed;
            r_used         <= n_used;
            r_batch_cnt    <= n_batch_cnt;
            r_out_vld      <= n_out_vld;
            r_chk_vld      <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_base       <= n_base;
        r_phys       <= n_phys;
        r_span       <= n_span;
        r_end        <= n_end;
        r_last       <= n_last;
        r_zero       <= n_zero;
        r_idx        <= n_idx;
        r_chk_idx    <= n_chk_idx;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_status     <= n_status;
        r_used_out   <= n_used_out;
    end

endmodule

### src/iorm_ram.sv
// Simple dual-port RAM with registered read data.
module iorm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/iorm_cmp.sv
// Range compare of one stored entry against the request: overlap and exact match.
module iorm_cmp import iorm_pkg::*; (
    input  t_entry                 i_entry,
    input  logic [ADDR_BITS-1:0]   i_base,
    input  logic [SPAN_BITS-1:0]   i_span,
    input  logic [END_BITS-1:0]    i_end,
    output t_cmp                   o_cmp
);

    logic [END_BITS-1:0] e_end;

    // ends at full width, half-open intervals
    assign e_end = END_BITS'(i_entry.io_base) + END_BITS'(i_entry.span);

    assign o_cmp.overlap = (END_BITS'(i_base) < e_end) &&
                           (END_BITS'(i_entry.io_base) < i_end);
    assign o_cmp.exact   = (i_entry.io_base == i_base) && (i_entry.span == i_span);

endmodule
